@@ hw/rtl/assert_macros.svh @@
// assertion helpers shared by the rtl files
// ASSERT_ALWAYS checks an expression at every clock edge outside reset
// ASSERT_NEXT checks that an antecedent is followed in the next cycle by a consequent
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("invariant violated");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sequence check failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/omr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omr_pkg
// types, codes and the type classifier of the overwriting message ring
// ----------------------------------------------------------------------------
package omr_pkg;

    localparam int KNOWN_TYPES = 18;
    localparam int CNT_SLOTS   = 19;
    localparam int CNT_ENTRIES = 2 * CNT_SLOTS;
    localparam int CNT_AW      = 6;
    localparam int CNT_W       = 32;
    localparam int TSLOT_W     = 5;

    // known type bytes in counter order: S R H Y L V W K A F E c X D U P I N
    localparam logic [7:0] KNOWN_CODES [KNOWN_TYPES] = '{
        8'h53, 8'h52, 8'h48, 8'h59, 8'h4C, 8'h56, 8'h57, 8'h4B, 8'h41,
        8'h46, 8'h45, 8'h63, 8'h58, 8'h44, 8'h55, 8'h50, 8'h49, 8'h4E
    };

    typedef enum logic [1:0] {
        KIND_ENQ    = 2'd0,
        KIND_DEQ    = 2'd1,
        KIND_REWIND = 2'd2,
        KIND_STAT   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_t;

    localparam logic [5:0] STAT_WRITE_WRAPS = 6'd38;
    localparam logic [5:0] STAT_READ_WRAPS  = 6'd39;
    localparam logic [5:0] STAT_WRITTEN     = 6'd40;
    localparam logic [5:0] STAT_READ        = 6'd41;
    localparam logic [5:0] STAT_FREE        = 6'd42;
    localparam logic [5:0] STAT_WRITE_SLOT  = 6'd43;

    // counter store access for one cycle
    typedef struct packed {
        logic              rd_en;
        logic [CNT_AW-1:0] rd_addr;
        logic              wr_en;
        logic [CNT_AW-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
    } cnt_req_t;

    // counter slot of a type byte, unknown types map to KNOWN_TYPES
    function automatic logic [TSLOT_W-1:0] type_slot(input logic [7:0] t);
        logic [TSLOT_W-1:0] slot;
        slot = TSLOT_W'(KNOWN_TYPES);
        for (int i = KNOWN_TYPES - 1; i >= 0; i--) begin
            if (KNOWN_CODES[i] == t) begin
                slot = TSLOT_W'(i);
            end
        end
        return slot;
    endfunction

endpackage

@@ hw/rtl/omr_ring_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omr_ring_mem
// message slot store: type byte and body word, one write and one read port
// ----------------------------------------------------------------------------
module omr_ring_mem #(
    parameter int DEPTH     = 1024,
    parameter int BODY_BITS = 64,
    localparam int AW       = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [7:0]           wr_type,
    input  logic [BODY_BITS-1:0] wr_body,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [7:0]           rd_type,
    output logic [BODY_BITS-1:0] rd_body
);

    logic [7:0]           type_mem [DEPTH];
    logic [BODY_BITS-1:0] body_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            type_mem[wr_addr] <= wr_type;
            body_mem[wr_addr] <= wr_body;
        end
        if (rd_en) begin
            rd_type <= type_mem[rd_addr];
            rd_body <= body_mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/omr_cnt_mem.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// omr_cnt_mem
// per-type enqueue and dequeue counters, entries read as zero until written
// ----------------------------------------------------------------------------
module omr_cnt_mem import omr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cnt_req_t         req,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0]       cnt_mem [CNT_ENTRIES];
    logic [CNT_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]       rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            cnt_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg  <= cnt_mem[req.rd_addr];
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

    `ASSERT_ALWAYS(a_wr_addr_range, aclk, aresetn, !req.wr_en || req.wr_addr < CNT_AW'(CNT_ENTRIES))
    `ASSERT_ALWAYS(a_rd_addr_range, aclk, aresetn, !req.rd_en || req.rd_addr < CNT_AW'(CNT_ENTRIES))

endmodule

@@ hw/rtl/overwriting_message_ring_with_stats.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// overwriting_message_ring_with_stats
// typed message ring that overwrites when full, with per-type statistics
// ----------------------------------------------------------------------------
// usage
//  - one command per input transfer on the s_ channel; tuser selects the kind
//    (enqueue, dequeue, rewind reader, read statistic), tdata carries type,
//    body and statistic index
//  - every command returns exactly one result transfer on the m_ channel:
//    status in tuser, dequeued type, body and statistic value in tdata
//  - one command is in flight at a time; s_tready is high while the
//    controller is idle
//  - with the receiver ready, a command steps through these states before
//    its result is registered and the next command is taken: EMIT for rewind
//    and a dequeue that finds the reader caught up, COUNT and EMIT for enqueue
//    and statistic read, LOOKUP, COUNT and EMIT for a dequeue that reads a
//    slot; set by the registered slot store read and the counter read-modify-write
//  - a registered result stage sits on the m_ side: when the receiver stalls,
//    the next command is still taken and completed up to its result, which
//    then waits until the stored result has been transferred
//  - reset (aresetn low, synchronous) empties the ring, zeroes all counters
//    and pointers and sets the free count to the ring depth; slot contents
//    are not cleared and are only read after being written
// ----------------------------------------------------------------------------
module overwriting_message_ring_with_stats import omr_pkg::*; #(
    parameter int RING_DEPTH = 1024,
    parameter int BODY_BITS  = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // command channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] message_type, [71:8] payload, [77:72] stat_index, [79:78] zero
    input  logic [79:0]  s_tdata,
    // [1:0] kind
    input  logic [1:0]   s_tuser,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] message_type_res, [71:8] payload_res, [135:72] stat_value
    output logic [135:0] m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int RW = $clog2(RING_DEPTH + 1);

    // one-hot controller states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_COUNT  = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    // field unpacking
    kind_t                in_kind;
    logic [7:0]           in_type;
    logic [BODY_BITS-1:0] in_body;
    logic [5:0]           in_sidx;

    assign in_kind = kind_t'(s_tuser);
    assign in_type = s_tdata[7:0];
    assign in_body = s_tdata[BODY_BITS+7:8];
    assign in_sidx = s_tdata[77:72];

    // control and pointer state
    state_t        state_reg, state_next;
    kind_t         op_reg, op_next;
    logic [AW-1:0] write_slot_reg, write_slot_next;
    logic [RW-1:0] read_slot_reg, read_slot_next;
    logic [RW-1:0] free_slots_reg, free_slots_next;
    logic [63:0]   written_total_reg, written_total_next;
    logic [63:0]   attempts_reg, attempts_next;
    logic [63:0]   read_total_reg, read_total_next;
    logic [31:0]   write_wraps_reg, write_wraps_next;
    logic [31:0]   read_wraps_reg, read_wraps_next;

    // per-command working registers
    logic [5:0]        sidx_reg, sidx_next;
    logic [CNT_AW-1:0] cnt_addr_reg, cnt_addr_next;
    status_t           pend_status_reg, pend_status_next;
    logic [7:0]        pend_type_reg, pend_type_next;
    logic [63:0]       pend_body_reg, pend_body_next;
    logic [63:0]       pend_stat_reg, pend_stat_next;

    // result stage
    logic         m_tvalid_reg, m_tvalid_next;
    logic [135:0] m_tdata_reg, m_tdata_next;
    logic [1:0]   m_tuser_reg, m_tuser_next;

    // memory ports
    logic                 ring_wr_en;
    logic                 ring_rd_en;
    logic [AW-1:0]        ring_rd_addr;
    logic [7:0]           ring_rd_type;
    logic [BODY_BITS-1:0] ring_rd_body;
    cnt_req_t             cnt_req;
    logic [CNT_W-1:0]     cnt_rd_data;

    // helpers
    logic                 in_xfer;
    logic                 out_free;
    logic [RW-1:0]        ws_inc;
    logic [RW-1:0]        rs_eff;
    logic [TSLOT_W-1:0]   in_tslot;
    logic [TSLOT_W-1:0]   rd_tslot;
    logic                 rd_known;
    logic [63:0]          stat_sel;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ws_inc   = RW'(write_slot_reg) + RW'(1);
    // a read slot parked at the end wraps on the next dequeue that reads
    assign rs_eff   = (read_slot_reg >= RW'(RING_DEPTH)) ? '0 : read_slot_reg;
    assign in_tslot = type_slot(in_type);
    assign rd_tslot = type_slot(ring_rd_type);
    assign rd_known = (rd_tslot != TSLOT_W'(KNOWN_TYPES));

    // statistic selection, counters come from the counter store read
    always_comb begin
        stat_sel = '0;
        if (sidx_reg < 6'(CNT_ENTRIES)) begin
            stat_sel = 64'(cnt_rd_data);
        end else begin
            case (sidx_reg)
                STAT_WRITE_WRAPS: stat_sel = 64'(write_wraps_reg);
                STAT_READ_WRAPS:  stat_sel = 64'(read_wraps_reg);
                STAT_WRITTEN:     stat_sel = written_total_reg;
                STAT_READ:        stat_sel = read_total_reg;
                STAT_FREE:        stat_sel = 64'(free_slots_reg);
                STAT_WRITE_SLOT:  stat_sel = 64'(write_slot_reg);
                default:          stat_sel = '0;
            endcase
        end
    end

    always_comb begin
        state_next         = state_reg;
        op_next            = op_reg;
        write_slot_next    = write_slot_reg;
        read_slot_next     = read_slot_reg;
        free_slots_next    = free_slots_reg;
        written_total_next = written_total_reg;
        attempts_next      = attempts_reg;
        read_total_next    = read_total_reg;
        write_wraps_next   = write_wraps_reg;
        read_wraps_next    = read_wraps_reg;
        sidx_next          = sidx_reg;
        cnt_addr_next      = cnt_addr_reg;
        pend_status_next   = pend_status_reg;
        pend_type_next     = pend_type_reg;
        pend_body_next     = pend_body_reg;
        pend_stat_next     = pend_stat_reg;
        m_tvalid_next      = m_tvalid_reg;
        m_tdata_next       = m_tdata_reg;
        m_tuser_next       = m_tuser_reg;

        ring_wr_en      = 1'b0;
        ring_rd_en      = 1'b0;
        ring_rd_addr    = rs_eff[AW-1:0];
        cnt_req         = '0;
        cnt_req.wr_addr = cnt_addr_reg;
        cnt_req.wr_data = cnt_rd_data + CNT_W'(1);

        // result stage drains independently of the controller
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    op_next          = in_kind;
                    sidx_next        = in_sidx;
                    pend_status_next = STATUS_OK;
                    pend_type_next   = '0;
                    pend_body_next   = '0;
                    pend_stat_next   = '0;
                    case (in_kind)
                        KIND_ENQ: begin
                            // store the message and count it by type
                            ring_wr_en         = 1'b1;
                            cnt_req.rd_en      = 1'b1;
                            cnt_req.rd_addr    = CNT_AW'(in_tslot);
                            cnt_addr_next      = CNT_AW'(in_tslot);
                            written_total_next = written_total_reg + 64'd1;
                            if (ws_inc == RW'(RING_DEPTH)) begin
                                write_slot_next  = '0;
                                free_slots_next  = RW'(RING_DEPTH);
                                write_wraps_next = write_wraps_reg + 32'd1;
                            end else begin
                                write_slot_next = ws_inc[AW-1:0];
                                if (free_slots_reg != '0) begin
                                    free_slots_next = free_slots_reg - RW'(1);
                                end
                            end
                            state_next = ST_COUNT;
                        end
                        KIND_DEQ: begin
                            if (attempts_reg >= written_total_reg) begin
                                // reader caught up with the writer
                                pend_status_next = STATUS_EMPTY;
                                state_next       = ST_EMIT;
                            end else begin
                                ring_rd_en     = 1'b1;
                                read_slot_next = rs_eff;
                                attempts_next  = attempts_reg + 64'd1;
                                if (read_slot_reg >= RW'(RING_DEPTH)) begin
                                    read_wraps_next = read_wraps_reg + 32'd1;
                                end
                                state_next = ST_LOOKUP;
                            end
                        end
                        KIND_REWIND: begin
                            read_slot_next = '0;
                            state_next     = ST_EMIT;
                        end
                        KIND_STAT: begin
                            if (in_sidx < 6'(CNT_ENTRIES)) begin
                                cnt_req.rd_en   = 1'b1;
                                cnt_req.rd_addr = in_sidx;
                            end
                            state_next = ST_COUNT;
                        end
                        default: begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                // slot data is back: classify and fetch its dequeue counter
                cnt_req.rd_en   = 1'b1;
                cnt_req.rd_addr = CNT_AW'(CNT_SLOTS) + CNT_AW'(rd_tslot);
                cnt_addr_next   = CNT_AW'(CNT_SLOTS) + CNT_AW'(rd_tslot);
                if (rd_known) begin
                    pend_type_next  = ring_rd_type;
                    pend_body_next  = 64'(ring_rd_body);
                    read_total_next = read_total_reg + 64'd1;
                    read_slot_next  = read_slot_reg + RW'(1);
                end else begin
                    // unknown type: flagged, read slot stays put
                    pend_status_next = STATUS_UNKNOWN;
                end
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                if (op_reg == KIND_STAT) begin
                    pend_stat_next = stat_sel;
                end else begin
                    cnt_req.wr_en = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {pend_stat_reg, pend_body_reg, pend_type_reg};
                    m_tuser_next  = pend_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            op_reg            <= KIND_ENQ;
            write_slot_reg    <= '0;
            read_slot_reg     <= '0;
            free_slots_reg    <= RW'(RING_DEPTH);
            written_total_reg <= '0;
            attempts_reg      <= '0;
            read_total_reg    <= '0;
            write_wraps_reg   <= '0;
            read_wraps_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            op_reg            <= op_next;
            write_slot_reg    <= write_slot_next;
            read_slot_reg     <= read_slot_next;
            free_slots_reg    <= free_slots_next;
            written_total_reg <= written_total_next;
            attempts_reg      <= attempts_next;
            read_total_reg    <= read_total_next;
            write_wraps_reg   <= write_wraps_next;
            read_wraps_reg    <= read_wraps_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        sidx_reg        <= sidx_next;
        cnt_addr_reg    <= cnt_addr_next;
        pend_status_reg <= pend_status_next;
        pend_type_reg   <= pend_type_next;
        pend_body_reg   <= pend_body_next;
        pend_stat_reg   <= pend_stat_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

    omr_ring_mem #(
        .DEPTH     (RING_DEPTH),
        .BODY_BITS (BODY_BITS)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr_en),
        .wr_addr (write_slot_reg),
        .wr_type (in_type),
        .wr_body (in_body),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_type (ring_rd_type),
        .rd_body (ring_rd_body)
    );

    omr_cnt_mem u_cnt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cnt_req),
        .rd_data (cnt_rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_ALWAYS(a_free_bound, aclk, aresetn, free_slots_reg <= RW'(RING_DEPTH))
    `ASSERT_ALWAYS(a_read_le_attempts, aclk, aresetn, read_total_reg <= attempts_reg)
    `ASSERT_ALWAYS(a_attempts_le_written, aclk, aresetn, attempts_reg <= written_total_reg)
    `ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready, state_reg != ST_IDLE)

endmodule

@@ bench/overwriting_message_ring_with_stats_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_message_ring_with_stats_tb
// self-checking bench for the overwriting message ring with statistics
// ----------------------------------------------------------------------------
// a queue of commands is built up front: a short directed opening, a full
// ring of enqueues, a long drain that walks the reader past the end of the
// ring, then a tail of unshaped commands. a bursty driver offers them on the
// s_ channel and every accepted transfer runs through a cycle-free ring
// predictor whose reply is queued. the monitor checks each m_ transfer
// against the oldest queued reply, field by field, while the receiver stalls
// on its own pattern and once holds off long enough to back up the block
// ----------------------------------------------------------------------------
module overwriting_message_ring_with_stats_tb;
    import omr_pkg::*;

    localparam int RING_SLOTS  = 1024;
    localparam int BODY_WIDTH  = 64;
    localparam int DRAIN_READS = 1030;
    localparam int NOISE_CMDS  = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 200;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 20;

    // statistic indexes that the package does not name
    localparam logic [5:0] STAT_ENQ_FIRST   = 6'd0;
    localparam logic [5:0] STAT_ENQ_UNKNOWN = 6'(CNT_SLOTS - 1);
    localparam logic [5:0] STAT_DEQ_FIRST   = 6'(CNT_SLOTS);
    localparam logic [5:0] STAT_DEQ_UNKNOWN = 6'(CNT_ENTRIES - 1);
    localparam logic [5:0] STAT_TOP         = 6'h3F;

    typedef struct {
        kind_t       kind;
        logic [7:0]  mtype;
        logic [63:0] body;
        logic [5:0]  stat_index;
    } ring_cmd_t;

    typedef struct {
        status_t     status;
        logic [7:0]  mtype;
        logic [63:0] body;
        logic [63:0] stat_value;
    } ring_reply_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata  = '0;
    logic [1:0]   s_tuser  = KIND_ENQ;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [1:0]   m_tuser;

    overwriting_message_ring_with_stats #(
        .RING_DEPTH (RING_SLOTS),
        .BODY_BITS  (BODY_WIDTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // ring predictor state
    // ------------------------------------------------------------------------
    logic [7:0]  ring_type [RING_SLOTS];
    logic [63:0] ring_body [RING_SLOTS];
    int          wr_slot   = 0;
    int          rd_slot   = 0;            // may sit at RING_SLOTS after the last slot
    logic [10:0] free_count = 11'(RING_SLOTS);
    logic [63:0] written_count = '0;
    logic [63:0] attempt_count = '0;
    logic [63:0] read_count    = '0;
    logic [31:0] wr_wraps = '0;
    logic [31:0] rd_wraps = '0;
    logic [31:0] enq_per_type [CNT_SLOTS] = '{default: '0};
    logic [31:0] deq_per_type [CNT_SLOTS] = '{default: '0};

    ring_cmd_t   pending_cmds [$];
    ring_reply_t ring_replies [$];

    int n_issued [4] = '{default: 0};
    int n_checked    = 0;
    int n_mismatch   = 0;

    // counter slot of a type byte, the unknown slot when no code matches
    function automatic int code_counter(logic [7:0] code);
        for (int k = 0; k < KNOWN_TYPES; k++) begin
            if (KNOWN_CODES[k] == code) return k;
        end
        return KNOWN_TYPES;
    endfunction

    function automatic logic [63:0] stat_of(logic [5:0] idx);
        if (idx < CNT_SLOTS) return 64'(enq_per_type[idx]);
        if (idx < CNT_ENTRIES) return 64'(deq_per_type[idx - CNT_SLOTS]);
        case (idx)
            STAT_WRITE_WRAPS: return 64'(wr_wraps);
            STAT_READ_WRAPS:  return 64'(rd_wraps);
            STAT_WRITTEN:     return written_count;
            STAT_READ:        return read_count;
            STAT_FREE:        return 64'(free_count);
            STAT_WRITE_SLOT:  return 64'(wr_slot);
            default:          return '0;
        endcase
    endfunction

    // advance the ring by one accepted command and queue its reply
    function automatic void ring_apply_command(ring_cmd_t cmd);
        ring_reply_t rep;
        int          slot;
        rep = '{STATUS_OK, 8'd0, 64'd0, 64'd0};
        case (cmd.kind)
            KIND_ENQ: begin
                ring_type[wr_slot] = cmd.mtype;
                ring_body[wr_slot] = cmd.body;
                written_count++;
                wr_slot++;
                if (wr_slot >= RING_SLOTS) begin
                    wr_slot    = 0;
                    free_count = 11'(RING_SLOTS);
                    wr_wraps++;
                end else if (free_count > 0) begin
                    free_count--;
                end
                enq_per_type[code_counter(cmd.mtype)]++;
            end
            KIND_DEQ: begin
                if (attempt_count >= written_count) begin
                    rep.status = STATUS_EMPTY;
                end else begin
                    if (rd_slot >= RING_SLOTS) begin
                        rd_slot = 0;
                        rd_wraps++;
                    end
                    attempt_count++;
                    slot = code_counter(ring_type[rd_slot]);
                    deq_per_type[slot]++;
                    if (slot == KNOWN_TYPES) begin
                        // unknown type holds the reader on this slot
                        rep.status = STATUS_UNKNOWN;
                    end else begin
                        read_count++;
                        rep.mtype = ring_type[rd_slot];
                        rep.body  = ring_body[rd_slot];
                        rd_slot++;
                    end
                end
            end
            KIND_REWIND: begin
                rd_slot = 0;
            end
            default: begin
                rep.stat_value = stat_of(cmd.stat_index);
            end
        endcase
        ring_replies.push_back(rep);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void add_cmd(kind_t k, logic [7:0] t, logic [63:0] b,
                                    logic [5:0] s);
        ring_cmd_t c;
        c.kind       = k;
        c.mtype      = t;
        c.body       = b;
        c.stat_index = s;
        pending_cmds.push_back(c);
    endfunction

    function automatic logic [63:0] any_body();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] any_known_code();
        return KNOWN_CODES[$urandom_range(0, KNOWN_TYPES - 1)];
    endfunction

    // random content in the fields that the kind ignores as well
    function automatic void add_random(kind_t k, logic [7:0] t);
        add_cmd(k, t, any_body(), 6'($urandom_range(0, 63)));
    endfunction

    // ------------------------------------------------------------------------
    // driver: bursts of random length with random gaps between them
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                n_issued[pending_cmds[0].kind]++;
                ring_apply_command(pending_cmds.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_cmds[0].kind;
                s_tdata  <= {2'b00, pending_cmds[0].stat_index,
                             pending_cmds[0].body, pending_cmds[0].mtype};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: runs of ready and short stalls, plus one long hold-off
    // ------------------------------------------------------------------------
    int  run_left   = 0;
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_checked >= HOLD_AFTER) begin
            // long hold-off so the result stage fills and s_tready drops
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (run_left > 0) begin
            m_tready <= 1'b1;
            run_left <= run_left - 1;
        end else begin
            m_tready   <= 1'b1;
            run_left   <= $urandom_range(1, 30);
            stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare each result transfer with the oldest queued reply
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        ring_reply_t exp_rep;
        if (aresetn && m_tvalid && m_tready) begin
            if (ring_replies.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("[%0t] result with nothing expected: status %0d tdata %h",
                             $realtime, m_tuser, m_tdata);
                end
            end else begin
                exp_rep = ring_replies.pop_front();
                if (m_tuser !== exp_rep.status || m_tdata[7:0] !== exp_rep.mtype ||
                    m_tdata[71:8] !== exp_rep.body ||
                    m_tdata[135:72] !== exp_rep.stat_value) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("[%0t] result %0d: expected status %0d type %h body %h stat %h",
                                 $realtime, n_checked, exp_rep.status, exp_rep.mtype,
                                 exp_rep.body, exp_rep.stat_value);
                        $display("[%0t] result %0d: actual   status %0d type %h body %h stat %h",
                                 $realtime, n_checked, m_tuser, m_tdata[7:0],
                                 m_tdata[71:8], m_tdata[135:72]);
                    end
                end
            end
            n_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles in a row without a transfer on either channel
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d commands and %0d replies left",
                     IDLE_LIMIT, pending_cmds.size(), ring_replies.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // command list, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [5:0] probe_idx [10];
        int         unknown_reads;
        probe_idx = '{STAT_ENQ_FIRST, STAT_ENQ_UNKNOWN, STAT_DEQ_FIRST, STAT_DEQ_UNKNOWN,
                      STAT_WRITE_WRAPS, STAT_READ_WRAPS, STAT_READ, STAT_WRITE_SLOT,
                      STAT_WRITE_SLOT + 6'd1, STAT_TOP};

        // directed opening: empty ring, extremes, unknown types, rewind
        add_cmd(KIND_DEQ, 8'h00, 64'd0, 6'd0);
        add_cmd(KIND_STAT, 8'h00, 64'd0, STAT_FREE);
        add_cmd(KIND_ENQ, KNOWN_CODES[0], 64'd0, 6'd0);
        add_cmd(KIND_ENQ, KNOWN_CODES[KNOWN_TYPES - 1], '1, 6'd0);
        add_cmd(KIND_ENQ, 8'h00, any_body(), 6'd0);
        add_cmd(KIND_ENQ, 8'hFF, any_body(), STAT_TOP);
        add_cmd(KIND_ENQ, KNOWN_CODES[11], any_body(), 6'd0);
        // two good reads, then the reader sticks on the unknown slot until caught up
        repeat (6) add_cmd(KIND_DEQ, 8'hFF, '1, STAT_TOP);
        add_cmd(KIND_REWIND, 8'h00, 64'd0, 6'd0);
        add_cmd(KIND_ENQ, KNOWN_CODES[12], any_body(), 6'd0);
        add_cmd(KIND_DEQ, 8'h00, 64'd0, 6'd0);
        foreach (probe_idx[p]) add_cmd(KIND_STAT, 8'h00, 64'd0, probe_idx[p]);

        // fill a whole ring of known messages so the writer wraps
        for (int i = 0; i < RING_SLOTS; i++) begin
            if ($urandom_range(0, 39) == 0) add_random(KIND_STAT, 8'($urandom()));
            add_random(KIND_ENQ, any_known_code());
        end

        // drain from slot 0 past the end of the ring so the reader wraps
        add_random(KIND_REWIND, 8'($urandom()));
        for (int i = 0; i < DRAIN_READS; i++) begin
            if ($urandom_range(0, 15) == 0) add_random(KIND_ENQ, any_known_code());
            if ($urandom_range(0, 39) == 0) add_random(KIND_STAT, 8'($urandom()));
            add_random(KIND_DEQ, 8'($urandom()));
        end

        // unshaped tail: any kind, any type byte, rewinds included
        for (int i = 0; i < NOISE_CMDS; i++) begin
            add_random(kind_t'($urandom_range(0, 3)),
                       ($urandom_range(0, 4) < 3) ? any_known_code() : 8'($urandom()));
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() > 0 || s_tvalid || ring_replies.size() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        unknown_reads = deq_per_type[KNOWN_TYPES];
        $display("commands: %0d enqueue, %0d dequeue, %0d rewind, %0d statistic; %0d results checked",
                 n_issued[KIND_ENQ], n_issued[KIND_DEQ], n_issued[KIND_REWIND],
                 n_issued[KIND_STAT], n_checked);
        $display("ring walked: %0d writer wraps, %0d reader wraps, %0d unknown-type reads, %0d mismatches",
                 wr_wraps, rd_wraps, unknown_reads, n_mismatch);
        if (n_mismatch == 0 && ring_replies.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ overwriting_message_ring_with_stats.f @@
+incdir+hw/rtl
hw/rtl/omr_pkg.sv
hw/rtl/omr_ring_mem.sv
hw/rtl/omr_cnt_mem.sv
hw/rtl/overwriting_message_ring_with_stats.sv
bench/overwriting_message_ring_with_stats_tb.sv
